@@ src/smtq_pkg.sv @@
`default_nettype none

package smtq_pkg;

    localparam int TIMERS_DEFAULT = 16;
    localparam int ID_SPAN        = 16;
    localparam int ID_W           = 4;
    localparam int TIME_W         = 32;
    localparam int INTERVAL_W     = 31;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_STOP    = 2'd1;
    localparam logic [1:0] OP_SERVICE = 2'd2;

    // one list slot: timer number and its remaining ticks
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] rem;
    } entry_t;

    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic              sub;
    } alu_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              le_zero;  // sum at or below zero, signed
        logic              lt;       // a < b, signed
    } alu_rsp_t;

endpackage

`default_nettype wire

@@ src/smtq_alu.sv @@
`default_nettype none

// Shared add/subtract and signed compare.
module smtq_alu (
    input  wire smtq_pkg::alu_req_t req,
    output smtq_pkg::alu_rsp_t      rsp
);

    logic [smtq_pkg::TIME_W-1:0] b_op;

    always_comb
    begin
        b_op        = req.sub ? ~req.b : req.b;
        rsp.sum     = req.a + b_op + {{(smtq_pkg::TIME_W-1){1'b0}}, req.sub};
        rsp.le_zero = (rsp.sum == '0) || rsp.sum[smtq_pkg::TIME_W-1];
        rsp.lt      = $signed(req.a) < $signed(req.b);
    end

endmodule

`default_nettype wire

@@ src/smtq_list.sv @@
`default_nettype none

// Ordered slot store: one write port, one indexed read, head tap.
module smtq_list #(
    parameter int SLOTS = smtq_pkg::ID_SPAN
) (
    input  wire                          clk,
    input  wire                          wr_en,
    input  wire  [$clog2(SLOTS)-1:0]     wr_idx,
    input  wire  smtq_pkg::entry_t       wr_entry,
    input  wire  [$clog2(SLOTS)-1:0]     rd_idx,
    output smtq_pkg::entry_t             rd_entry,
    output logic [smtq_pkg::TIME_W-1:0]  head_rem
);

    smtq_pkg::entry_t slot_reg [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_idx] <= wr_entry;
        end
    end

    assign rd_entry = slot_reg[rd_idx];
    assign head_rem = slot_reg[0].rem;

endmodule

`default_nettype wire

@@ src/sorted_multi_timer_queue.sv @@
`default_nettype none

// Sorted one-shot timer queue. Pulse start for one cycle while busy is low to hand in a
// word (op, timer_id, interval, now). busy then stays high until the final result of that
// word is on the ports, and a new word can be taken in that same cycle. Results come out
// on consecutive cycles, each marked by strobe for exactly one cycle, with last set on the
// final one. They cannot be held off, so the receiver must take every strobed cycle. A
// service word gives one result per expired timer (in list order), or a single result with
// expired_valid low if none expired. Start, stop and unused op codes give one result.
// head_remaining and list_empty show the list after the whole word is done, on every
// result of that word.
// The list walk goes through the single add/compare unit, one slot per cycle. No clearing
// pass follows reset.
module sorted_multi_timer_queue #(
    parameter int TIMERS = smtq_pkg::TIMERS_DEFAULT
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire  [1:0]                         op,
    input  wire  [smtq_pkg::ID_W-1:0]          timer_id,
    input  wire  [smtq_pkg::INTERVAL_W-1:0]    interval,
    input  wire  [smtq_pkg::TIME_W-1:0]        now,
    output logic                               strobe,
    output logic                               expired_valid,
    output logic [smtq_pkg::ID_W-1:0]          expired_id,
    output logic signed [smtq_pkg::TIME_W-1:0] head_remaining,
    output logic                               list_empty,
    output logic                               last
);

    // only ids the id field can carry are ever listed
    localparam int SLOTS = (TIMERS < smtq_pkg::ID_SPAN) ? TIMERS : smtq_pkg::ID_SPAN;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;  // elapsed = now - last_wait
    localparam logic [2:0] ST_SCAN = 3'd2;  // compacting walk: remove / charge time
    localparam logic [2:0] ST_VAL  = 3'd3;  // start value
    localparam logic [2:0] ST_INS  = 3'd4;  // inserting walk with carry slot
    localparam logic [2:0] ST_EMIT = 3'd5;  // one result per cycle

    logic [2:0]                        state_reg, state_next;
    logic [1:0]                        op_reg, op_next;
    logic [smtq_pkg::ID_W-1:0]         id_reg, id_next;
    logic [smtq_pkg::INTERVAL_W-1:0]   interval_reg, interval_next;
    logic [smtq_pkg::TIME_W-1:0]       now_reg, now_next;
    logic [smtq_pkg::TIME_W-1:0]       elapsed_reg, elapsed_next;
    logic [smtq_pkg::TIME_W-1:0]       last_wait_reg, last_wait_next;
    logic [smtq_pkg::TIME_W-1:0]       val_reg, val_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [CNT_W-1:0]                  i_reg, i_next;
    logic [CNT_W-1:0]                  w_reg, w_next;
    logic [CNT_W-1:0]                  nexp_reg, nexp_next;
    logic [CNT_W-1:0]                  e_reg, e_next;
    logic                              placed_reg, placed_next;
    smtq_pkg::entry_t                  carry_reg, carry_next;

    logic                              strobe_reg, strobe_next;
    logic                              xv_reg, xv_next;
    logic [smtq_pkg::ID_W-1:0]         xid_reg, xid_next;
    logic [smtq_pkg::TIME_W-1:0]       head_reg, head_next;
    logic                              empty_reg, empty_next;
    logic                              last_reg, last_next;

    // expired ids of one service word, held until the list is final
    logic [smtq_pkg::ID_W-1:0]         exp_buf_reg [SLOTS];
    logic                              exp_wr;

    smtq_pkg::alu_req_t                alu_req;
    smtq_pkg::alu_rsp_t                alu_rsp;

    logic                              wr_en;
    logic [IDX_W-1:0]                  wr_idx;
    smtq_pkg::entry_t                  wr_entry;
    smtq_pkg::entry_t                  rd_entry;
    logic [smtq_pkg::TIME_W-1:0]       head_rem;

    logic                              id_ok;
    logic                              is_service;
    logic                              drop;
    logic                              emit_last;
    smtq_pkg::entry_t                  new_entry;

    smtq_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    smtq_list #(
        .SLOTS (SLOTS)
    ) u_list (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_entry (wr_entry),
        .rd_idx   (i_reg[IDX_W-1:0]),
        .rd_entry (rd_entry),
        .head_rem (head_rem)
    );

    assign id_ok      = 32'(id_reg) < 32'(TIMERS);
    assign is_service = (op_reg == smtq_pkg::OP_SERVICE);
    assign emit_last  = (nexp_reg == '0) || (e_reg == nexp_reg - CNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        interval_next  = interval_reg;
        now_next       = now_reg;
        elapsed_next   = elapsed_reg;
        last_wait_next = last_wait_reg;
        val_next       = val_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        w_next         = w_reg;
        nexp_next      = nexp_reg;
        e_next         = e_reg;
        placed_next    = placed_reg;
        carry_next     = carry_reg;
        strobe_next    = 1'b0;
        xv_next        = xv_reg;
        xid_next       = xid_reg;
        head_next      = head_reg;
        empty_next     = empty_reg;
        last_next      = last_reg;
        exp_wr         = 1'b0;
        wr_en          = 1'b0;
        wr_idx         = i_reg[IDX_W-1:0];
        wr_entry       = rd_entry;
        drop           = 1'b0;
        new_entry.id   = id_reg;
        new_entry.rem  = val_reg;
        alu_req.a      = rd_entry.rem;
        alu_req.b      = elapsed_reg;
        alu_req.sub    = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next       = op;
                    id_next       = timer_id;
                    interval_next = interval;
                    now_next      = now;
                    state_next    = ST_PREP;
                end
            end

            ST_PREP:
            begin
                alu_req.a    = now_reg;
                alu_req.b    = last_wait_reg;
                alu_req.sub  = 1'b1;
                elapsed_next = alu_rsp.sum;
                i_next       = '0;
                w_next       = '0;
                nexp_next    = '0;
                e_next       = '0;
                if (is_service || (id_ok && (op_reg == smtq_pkg::OP_START ||
                                             op_reg == smtq_pkg::OP_STOP)))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_SCAN:
            begin
                if (i_reg == cnt_reg)
                begin
                    cnt_next = w_reg;
                    if (is_service)
                    begin
                        last_wait_next = now_reg;
                        state_next     = ST_EMIT;
                    end
                    else if (op_reg == smtq_pkg::OP_START)
                    begin
                        state_next = ST_VAL;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    wr_idx = w_reg[IDX_W-1:0];
                    if (is_service)
                    begin
                        drop         = alu_rsp.le_zero;
                        wr_entry.rem = alu_rsp.sum;
                    end
                    else
                    begin
                        drop = (rd_entry.id == id_reg);
                    end
                    if (!drop)
                    begin
                        wr_en  = 1'b1;
                        w_next = w_reg + CNT_W'(1);
                    end
                    else if (is_service)
                    begin
                        exp_wr    = 1'b1;
                        nexp_next = nexp_reg + CNT_W'(1);
                    end
                    i_next = i_reg + CNT_W'(1);
                end
            end

            ST_VAL:
            begin
                alu_req.a   = {1'b0, interval_reg};
                alu_req.b   = elapsed_reg;
                alu_req.sub = 1'b0;
                if (cnt_reg == '0)
                begin
                    last_wait_next = now_reg;
                    val_next       = {1'b0, interval_reg};
                end
                else
                begin
                    val_next = alu_rsp.sum;
                end
                i_next      = '0;
                placed_next = 1'b0;
                if (cnt_reg == CNT_W'(SLOTS))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_INS;
                end
            end

            ST_INS:
            begin
                alu_req.a   = val_reg;
                alu_req.b   = rd_entry.rem;
                alu_req.sub = 1'b0;
                if (placed_reg)
                begin
                    wr_en      = 1'b1;
                    wr_entry   = carry_reg;
                    carry_next = rd_entry;
                end
                else if ((i_reg == cnt_reg) || alu_rsp.lt)
                begin
                    wr_en       = 1'b1;
                    wr_entry    = new_entry;
                    carry_next  = rd_entry;
                    placed_next = 1'b1;
                end
                if (i_reg == cnt_reg)
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_EMIT;
                end
                else
                begin
                    i_next = i_reg + CNT_W'(1);
                end
            end

            ST_EMIT:
            begin
                strobe_next = 1'b1;
                xv_next     = (nexp_reg != '0);
                xid_next    = (nexp_reg != '0) ? exp_buf_reg[e_reg[IDX_W-1:0]] : '0;
                empty_next  = (cnt_reg == '0);
                head_next   = (cnt_reg == '0) ? '0 : head_rem;
                last_next   = emit_last;
                e_next      = e_reg + CNT_W'(1);
                if (emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            last_wait_reg <= '0;
            strobe_reg    <= 1'b0;
            i_reg         <= '0;
            w_reg         <= '0;
            nexp_reg      <= '0;
            e_reg         <= '0;
            placed_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_wait_reg <= last_wait_next;
            strobe_reg    <= strobe_next;
            i_reg         <= i_next;
            w_reg         <= w_next;
            nexp_reg      <= nexp_next;
            e_reg         <= e_next;
            placed_reg    <= placed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        interval_reg <= interval_next;
        now_reg      <= now_next;
        elapsed_reg  <= elapsed_next;
        val_reg      <= val_next;
        carry_reg    <= carry_next;
        xv_reg       <= xv_next;
        xid_reg      <= xid_next;
        head_reg     <= head_next;
        empty_reg    <= empty_next;
        last_reg     <= last_next;
        if (exp_wr)
        begin
            exp_buf_reg[nexp_reg[IDX_W-1:0]] <= rd_entry.id;
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign strobe         = strobe_reg;
    assign expired_valid  = xv_reg;
    assign expired_id     = xid_reg;
    assign head_remaining = head_reg;
    assign list_empty     = empty_reg;
    assign last           = last_reg;

    // list never holds more than its slots
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(SLOTS))
        else $error("listed count beyond slots");

    // insertion only runs with a free slot
    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS) |-> (cnt_reg < CNT_W'(SLOTS)))
        else $error("insert into full list");

    // results of one word come back to back
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("gap inside result burst");

    // a burst ends and the block goes idle
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !busy)
        else $error("busy after final result");

    // accepted word makes the block busy
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !strobe))
        else $error("accept did not start work");

endmodule

`default_nettype wire
